@@ hw/rtl/hfbe_pkg.sv @@
package hfbe_pkg;

  // Frame command codes
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_FLAG  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  // Byte segments of an end-of-frame command
  typedef enum logic [1:0] {
    SEG_LO   = 2'd0,
    SEG_HI   = 2'd1,
    SEG_FLAG = 2'd2
  } seg_t;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [2:0]  RUN_LIMIT  = 3'd5;
  localparam logic [7:0]  FLAG_RESET = 8'h7E;

  // Command queue between front and back
  localparam int IQ_AW    = 2;
  localparam int IQ_DEPTH = 2 ** IQ_AW;

  // Symbol queue on the result side
  localparam int OQ_AW    = 1;
  localparam int OQ_DEPTH = 2 ** OQ_AW;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } cmd_word_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic      valid;
    cmd_word_t word;
  } cmd_head_t;

  typedef struct packed {
    logic tone;
    logic stuffed;
    logic last;
  } sym_t;

endpackage

@@ hw/rtl/hfbe_front.sv @@
module hfbe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_data_byte,
  output hfbe_pkg::cmd_head_t  head,
  input  logic                 take
);

  hfbe_pkg::cmd_word_t          q_r [hfbe_pkg::IQ_DEPTH];
  logic [hfbe_pkg::IQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hfbe_pkg::IQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [hfbe_pkg::IQ_AW:0]     cnt_r, cnt_nxt;
  logic                         wr_en;
  logic                         rd_en;
  hfbe_pkg::cmd_word_t          word_in;

  // Classify the incoming word
  always_comb begin
    word_in.cmd  = hfbe_pkg::cmd_t'(in_cmd);
    word_in.data = (word_in.cmd == hfbe_pkg::CMD_DATA) ? in_data_byte : 8'h00;
  end

  assign full  = (cnt_r == (hfbe_pkg::IQ_AW+1)'(hfbe_pkg::IQ_DEPTH));
  assign wr_en = push & ~full;
  assign rd_en = take & head.valid;

  assign head.valid = (cnt_r != '0);
  assign head.word  = q_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= word_in;
    end
  end

endmodule

@@ hw/rtl/hfbe_back.sv @@
module hfbe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  hfbe_pkg::cmd_head_t  head,
  output logic                 take,
  input  logic                 room,
  output logic                 sym_push,
  output hfbe_pkg::sym_t       sym
);

  logic [7:0]       flag_r;
  logic [15:0]      crc_r, crc_nxt;
  logic             tone_r, tone_nxt;
  logic [2:0]       run_r, run_nxt;
  logic             busy_r, busy_nxt;
  hfbe_pkg::cmd_t   op_r, op_nxt;
  hfbe_pkg::seg_t   seg_r, seg_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             stuff_r, stuff_nxt;

  logic             cur_bit;
  logic             is_flag;
  logic             final_seg;
  logic [2:0]       run0;
  logic [2:0]       run_inc;
  logic [15:0]      crc_adv;
  logic             bit_done;
  logic             end_bit;

  assign take      = ~busy_r & head.valid;
  assign sym_push  = busy_r & room;
  assign cur_bit   = shift_r[idx_r];
  assign is_flag   = (op_r == hfbe_pkg::CMD_FLAG) ||
                     ((op_r == hfbe_pkg::CMD_END) && (seg_r == hfbe_pkg::SEG_FLAG));
  assign final_seg = (op_r != hfbe_pkg::CMD_END) || (seg_r == hfbe_pkg::SEG_FLAG);
  assign end_bit   = (idx_r == 3'd7) && final_seg;
  assign run0      = is_flag ? 3'd0 : run_r;
  assign run_inc   = run0 + 3'd1;
  assign crc_adv   = (crc_r >> 1) ^ ((crc_r[0] ^ cur_bit) ? hfbe_pkg::CRC_POLY : 16'h0000);

  // Hold the flag pattern register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= hfbe_pkg::FLAG_RESET;
    end else if (cfg_we) begin
      flag_r <= cfg_wdata;
    end
  end

  // Serialize one bit or one stuffed zero per step
  always_comb begin
    crc_nxt   = crc_r;
    tone_nxt  = tone_r;
    run_nxt   = run_r;
    busy_nxt  = busy_r;
    op_nxt    = op_r;
    seg_nxt   = seg_r;
    shift_nxt = shift_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    stuff_nxt = stuff_r;
    bit_done  = 1'b0;
    sym       = '0;

    // Load a new command
    if (take) begin
      op_nxt  = head.word.cmd;
      seg_nxt = hfbe_pkg::SEG_LO;
      idx_nxt = 3'd0;
      unique case (head.word.cmd)
        hfbe_pkg::CMD_START: begin
          crc_nxt  = hfbe_pkg::CRC_PRESET;
          tone_nxt = 1'b1;
        end
        hfbe_pkg::CMD_DATA: begin
          busy_nxt  = 1'b1;
          shift_nxt = head.word.data;
        end
        hfbe_pkg::CMD_FLAG: begin
          busy_nxt  = 1'b1;
          shift_nxt = flag_r;
        end
        hfbe_pkg::CMD_END: begin
          busy_nxt  = 1'b1;
          shift_nxt = ~crc_r[7:0];
          hi_nxt    = ~crc_r[15:8];
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end

    // Emit one symbol
    if (sym_push) begin
      if (stuff_r) begin
        tone_nxt  = ~tone_r;
        stuff_nxt = 1'b0;
        bit_done  = 1'b1;
        sym       = '{tone: ~tone_r, stuffed: 1'b1, last: end_bit};
      end else begin
        if (!is_flag) begin
          crc_nxt = crc_adv;
        end
        if (cur_bit) begin
          if (run_inc == hfbe_pkg::RUN_LIMIT) begin
            stuff_nxt = 1'b1;
            run_nxt   = 3'd0;
            sym       = '{tone: tone_r, stuffed: 1'b0, last: 1'b0};
          end else begin
            run_nxt  = run_inc;
            bit_done = 1'b1;
            sym      = '{tone: tone_r, stuffed: 1'b0, last: end_bit};
          end
        end else begin
          run_nxt  = 3'd0;
          tone_nxt = ~tone_r;
          bit_done = 1'b1;
          sym      = '{tone: ~tone_r, stuffed: 1'b0, last: end_bit};
        end
      end

      // Advance to the next bit, segment or finish
      if (bit_done) begin
        if (idx_r == 3'd7) begin
          if (final_seg) begin
            busy_nxt = 1'b0;
          end else begin
            idx_nxt = 3'd0;
            if (seg_r == hfbe_pkg::SEG_LO) begin
              seg_nxt   = hfbe_pkg::SEG_HI;
              shift_nxt = hi_r;
            end else begin
              seg_nxt   = hfbe_pkg::SEG_FLAG;
              shift_nxt = flag_r;
            end
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= hfbe_pkg::CRC_PRESET;
      tone_r  <= 1'b1;
      run_r   <= 3'd0;
      busy_r  <= 1'b0;
      stuff_r <= 1'b0;
      op_r    <= hfbe_pkg::CMD_START;
      seg_r   <= hfbe_pkg::SEG_LO;
      idx_r   <= 3'd0;
    end else begin
      crc_r   <= crc_nxt;
      tone_r  <= tone_nxt;
      run_r   <= run_nxt;
      busy_r  <= busy_nxt;
      stuff_r <= stuff_nxt;
      op_r    <= op_nxt;
      seg_r   <= seg_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    hi_r    <= hi_nxt;
  end

  // The run counter never holds the limit: reaching it schedules a stuffed zero
  a_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < hfbe_pkg::RUN_LIMIT)
    else $error("ones run reached the stuffing limit");

  // A pending stuffed zero belongs to the item at work
  a_stuff_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stuff_r |-> busy_r)
    else $error("stuffed zero pending while idle");

  // A stuffed zero is scheduled only right after a one bit of the same item
  a_stuff_after_one: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stuff_r) |-> $past(sym_push && !sym.stuffed && !sym.last))
    else $error("stuffed symbol without a preceding one bit");

endmodule

@@ hw/rtl/hfbe_out_fifo.sv @@
module hfbe_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            sym_push,
  input  hfbe_pkg::sym_t  sym,
  output logic            room,
  output logic            empty,
  input  logic            pop,
  output logic            out_tone,
  output logic            out_stuffed,
  output logic            out_last
);

  hfbe_pkg::sym_t               q_r [hfbe_pkg::OQ_DEPTH];
  logic [hfbe_pkg::OQ_AW-1:0]   wr_ptr_r;
  logic [hfbe_pkg::OQ_AW-1:0]   rd_ptr_r;
  logic [hfbe_pkg::OQ_AW:0]     cnt_r, cnt_nxt;
  logic                         rd_en;
  hfbe_pkg::sym_t               head;

  assign room  = (cnt_r != (hfbe_pkg::OQ_AW+1)'(hfbe_pkg::OQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_en = pop & ~empty;

  assign head        = q_r[rd_ptr_r];
  assign out_tone    = head.tone;
  assign out_stuffed = head.stuffed;
  assign out_last    = head.last;

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (sym_push && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!sym_push && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (sym_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Store the symbol
  always_ff @(posedge clk) begin
    if (sym_push) begin
      q_r[wr_ptr_r] <= sym;
    end
  end

  // No symbol is written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    sym_push |-> room)
    else $error("symbol written into full result queue");

endmodule

@@ hw/rtl/hdlc_frame_bit_encoder.sv @@
// Channel   Handshake       Payload
// input     push / full     in_cmd[1:0], in_data_byte[7:0]
// result    empty / pop     out_tone, out_stuffed, out_last
// config    cfg_we          cfg_wdata[7:0] (flag pattern)
//
// One tone symbol per cycle leaves the serializer while a word is at work and the result queue has room.
// A data word is loaded and then sent as 8 to 10 symbols, a flag word as 8, an end
// word as 24 to 28, and a start word sends none; the serializer takes one word at a time.
// A 4-word command queue lets new words enter while the serializer works.
// Reset (rst_n low, synchronous) empties both queues, presets the CRC to all ones,
// the tone to mark and the flag pattern to 0x7E; a stalled result queue stops the
// serializer and then fills the command queue until full rises.
module hdlc_frame_bit_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_tone,
  output logic        out_stuffed,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  hfbe_pkg::cmd_head_t head;
  logic                take;
  logic                room;
  logic                sym_push;
  hfbe_pkg::sym_t      sym;

  hfbe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .head         (head),
    .take         (take)
  );

  hfbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .take      (take),
    .room      (room),
    .sym_push  (sym_push),
    .sym       (sym)
  );

  hfbe_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .sym_push    (sym_push),
    .sym         (sym),
    .room        (room),
    .empty       (empty),
    .pop         (pop),
    .out_tone    (out_tone),
    .out_stuffed (out_stuffed),
    .out_last    (out_last)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int SYM_DEPTH      = 16384;
  localparam int IDLE_PAUSE     = 40;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_WORDS   = 215;
  localparam int SETTLE_CYCLES  = 60;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       push         = 1'b0;
  logic       full;
  logic [1:0] in_cmd       = hfbe_pkg::CMD_START;
  logic [7:0] in_data_byte = 8'h00;
  logic       empty;
  logic       pop          = 1'b0;
  logic       out_tone;
  logic       out_stuffed;
  logic       out_last;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = 8'h00;

  // Encoder state mirrored by the testbench
  logic [15:0] crc_model;
  logic        tone_model;
  logic [2:0]  run_model;
  logic [7:0]  flag_model;

  // Symbols predicted but not yet popped, as a ring with two counters
  hfbe_pkg::sym_t pending_syms [SYM_DEPTH];
  int   syms_pushed = 0;
  int   syms_popped = 0;
  int   word_len;

  int   mismatches  = 0;
  bit   leftover    = 1'b0;
  bit   random_idle = 1'b1;
  int   holdoff_req = 0;
  int   holdoff_seen = 0;
  int   pop_wait = 0;
  int   pop_gap;
  int   stall_cycles = 0;
  hfbe_pkg::sym_t want;
  bit   bad;

  hdlc_frame_bit_encoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_cmd      (in_cmd),
    .in_data_byte(in_data_byte),
    .empty       (empty),
    .pop         (pop),
    .out_tone    (out_tone),
    .out_stuffed (out_stuffed),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 94) return $urandom_range(1, 3);
    else return $urandom_range(12, 60);
  endfunction

  // Favor bytes with long runs of ones so stuffing happens often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1: return 8'hFF ^ (8'd1 << 3'($urandom_range(0, 7)));
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append one symbol at the current tone
  task automatic emit_sym(input bit stuffed_bit);
    int slot;
    slot = (syms_pushed + word_len) % SYM_DEPTH;
    pending_syms[slot].tone    = tone_model;
    pending_syms[slot].stuffed = stuffed_bit;
    pending_syms[slot].last    = 1'b0;
    word_len++;
  endtask

  // Serialize one byte LSB first with NRZI, stuffing and CRC for non-flag bytes
  task automatic encode_byte(input logic [7:0] value, input bit is_flag);
    logic b;
    logic mix;
    for (int i = 0; i < 8; i++) begin
      b = value[i];
      if (is_flag) begin
        run_model = '0;
      end else begin
        mix = crc_model[0] ^ b;
        crc_model = crc_model >> 1;
        if (mix) crc_model = crc_model ^ hfbe_pkg::CRC_POLY;
      end
      if (b) begin
        run_model = run_model + 3'd1;
        emit_sym(1'b0);
        if (run_model == hfbe_pkg::RUN_LIMIT) begin
          tone_model = ~tone_model;
          emit_sym(1'b1);
          run_model = '0;
        end
      end else begin
        run_model = '0;
        tone_model = ~tone_model;
        emit_sym(1'b0);
      end
    end
  endtask

  // Predict all symbols caused by one command word
  task automatic encode_word(input hfbe_pkg::cmd_t cmd, input logic [7:0] data);
    logic [7:0] crc_lo;
    logic [7:0] crc_hi;
    word_len = 0;
    case (cmd)
      hfbe_pkg::CMD_START: begin
        crc_model  = hfbe_pkg::CRC_PRESET;
        tone_model = 1'b1;
      end
      hfbe_pkg::CMD_DATA: encode_byte(data, 1'b0);
      hfbe_pkg::CMD_FLAG: encode_byte(flag_model, 1'b1);
      hfbe_pkg::CMD_END: begin
        crc_lo = ~crc_model[7:0];
        crc_hi = ~crc_model[15:8];
        encode_byte(crc_lo, 1'b0);
        encode_byte(crc_hi, 1'b0);
        encode_byte(flag_model, 1'b1);
      end
    endcase
    if (word_len > 0) begin
      pending_syms[(syms_pushed + word_len - 1) % SYM_DEPTH].last = 1'b1;
      syms_pushed = syms_pushed + word_len;
    end
  endtask

  // Offer one word after an optional gap; push stays high on return
  task automatic send_word(input hfbe_pkg::cmd_t cmd, input logic [7:0] data);
    int gap;
    gap = random_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push         <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= data;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_word(cmd, data);
  endtask

  // Drop push and wait until every predicted symbol has been popped
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (syms_popped != syms_pushed) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  task automatic write_flag(input logic [7:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    flag_model = value;
  endtask

  // Edge cases: stuffing at byte end, run kept across start, residue, ignored data
  task automatic test_directed_words();
    send_word(hfbe_pkg::CMD_START, 8'h00);
    send_word(hfbe_pkg::CMD_DATA, 8'h00);
    send_word(hfbe_pkg::CMD_DATA, 8'hFF);
    send_word(hfbe_pkg::CMD_DATA, 8'h1F);
    send_word(hfbe_pkg::CMD_DATA, 8'hF8);
    send_word(hfbe_pkg::CMD_DATA, 8'hAA);
    send_word(hfbe_pkg::CMD_DATA, 8'h55);
    send_word(hfbe_pkg::CMD_FLAG, 8'hFF);
    send_word(hfbe_pkg::CMD_DATA, 8'hFF);
    send_word(hfbe_pkg::CMD_END, 8'hA5);
    send_word(hfbe_pkg::CMD_END, 8'h5A);
    send_word(hfbe_pkg::CMD_START, 8'hFF);
    send_word(hfbe_pkg::CMD_DATA, 8'hF0);
    send_word(hfbe_pkg::CMD_START, 8'h00);
    send_word(hfbe_pkg::CMD_DATA, 8'h01);
    send_word(hfbe_pkg::CMD_FLAG, 8'h00);
    send_word(hfbe_pkg::CMD_END, 8'hFF);
    send_word(hfbe_pkg::CMD_START, 8'h3C);
    send_word(hfbe_pkg::CMD_END, 8'h00);
    send_word(hfbe_pkg::CMD_DATA, 8'h7F);
    send_word(hfbe_pkg::CMD_DATA, 8'h80);
  endtask

  // Run short frames under the flag pattern extremes and restore the default
  task automatic test_flag_patterns();
    logic [7:0] patterns [4];
    patterns = '{8'hFF, 8'h00, 8'h80, hfbe_pkg::FLAG_RESET};
    foreach (patterns[p]) begin
      write_flag(patterns[p]);
      send_word(hfbe_pkg::CMD_START, 8'h00);
      send_word(hfbe_pkg::CMD_FLAG, 8'h00);
      send_word(hfbe_pkg::CMD_DATA, 8'h0F);
      send_word(hfbe_pkg::CMD_DATA, pick_byte());
      send_word(hfbe_pkg::CMD_FLAG, 8'hFF);
      send_word(hfbe_pkg::CMD_END, 8'h00);
    end
  endtask

  // Hold the receiver off while words keep coming, so full must rise
  task automatic test_fill_stall();
    random_idle = 1'b0;
    holdoff_req++;
    for (int f = 0; f < 4; f++) begin
      send_word(hfbe_pkg::CMD_START, 8'($urandom_range(0, 255)));
      for (int k = 0; k < 4; k++) send_word(hfbe_pkg::CMD_DATA, pick_byte());
      send_word(hfbe_pkg::CMD_END, 8'($urandom_range(0, 255)));
    end
    random_idle = 1'b1;
  endtask

  // Back-to-back frames with no idling on either side
  task automatic test_back_to_back();
    random_idle = 1'b0;
    for (int f = 0; f < 5; f++) begin
      send_word(hfbe_pkg::CMD_START, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 6)) send_word(hfbe_pkg::CMD_DATA, pick_byte());
      send_word(hfbe_pkg::CMD_END, 8'($urandom_range(0, 255)));
    end
    random_idle = 1'b1;
  endtask

  // Mostly well-formed frames, some broken sequences and stray commands
  task automatic test_random_frames();
    int sent;
    int n;
    int r;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      random_idle = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 24) == 0) write_flag(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        send_word(hfbe_pkg::CMD_START, 8'($urandom_range(0, 255)));
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 7) == 0)
            send_word(hfbe_pkg::CMD_FLAG, 8'($urandom_range(0, 255)));
          else send_word(hfbe_pkg::CMD_DATA, pick_byte());
        end
        send_word(hfbe_pkg::CMD_END, 8'($urandom_range(0, 255)));
        sent = sent + n + 2;
      end else if (r < 90) begin
        n = $urandom_range(2, 5);
        for (int k = 0; k < n; k++)
          send_word(hfbe_pkg::cmd_t'(2'($urandom_range(1, 3))), pick_byte());
        sent = sent + n;
      end else begin
        send_word(hfbe_pkg::cmd_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
        sent++;
      end
    end
    random_idle = 1'b1;
  endtask

  // Receiver: random pops, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen = holdoff_req;
      pop_wait = HOLDOFF_CYCLES;
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop_wait--;
      pop <= 1'b0;
    end else if (random_idle) begin
      pop_gap = pick_gap();
      if (pop_gap == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        pop_wait = pop_gap - 1;
      end
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each popped symbol against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (syms_popped == syms_pushed) begin
        $error("unexpected symbol: tone=%0b stuffed=%0b last=%0b",
               out_tone, out_stuffed, out_last);
        mismatches++;
      end else begin
        want = pending_syms[syms_popped % SYM_DEPTH];
        bad  = 1'b0;
        if (out_tone !== want.tone) begin
          $error("tone: expected %0b, got %0b", want.tone, out_tone);
          bad = 1'b1;
        end
        if (out_stuffed !== want.stuffed) begin
          $error("stuffed: expected %0b, got %0b", want.stuffed, out_stuffed);
          bad = 1'b1;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          bad = 1'b1;
        end
        if (bad) mismatches++;
        syms_popped++;
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    crc_model  = hfbe_pkg::CRC_PRESET;
    tone_model = 1'b1;
    run_model  = '0;
    flag_model = hfbe_pkg::FLAG_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_words();
    test_flag_patterns();
    test_fill_stall();
    test_back_to_back();
    test_random_frames();

    // Let the last words drain, then settle
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (syms_popped != syms_pushed) begin
      $error("%0d predicted symbols never arrived", syms_pushed - syms_popped);
      leftover = 1'b1;
    end
    if (mismatches == 0 && !leftover) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
